[sv/v3a_pkg.sv]
// Shared opcodes, port widths and parameter defaults for the vector ALU.
package v3a_pkg;

	localparam int IO_BITS        = 32;
	localparam int OP_BITS        = 3;
	localparam int WORD_BITS_DEF  = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_DOT   = 3'd2,
		OP_CROSS = 3'd3,
		OP_SCALE = 3'd4,
		OP_DIV   = 3'd5,
		OP_MAG   = 3'd6,
		OP_NORM  = 3'd7
	} opcode_t;

endpackage

[sv/v3a_lane.sv]
// One component lane: operand select, product stage, per-lane combine stage.
module v3a_lane #(
	parameter int W = v3a_pkg::WORD_BITS_DEF,
	parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  v3a_pkg::opcode_t      op,
	input  logic signed [W-1:0]   a_i,
	input  logic signed [W-1:0]   b_i,
	input  logic signed [W-1:0]   a_j,
	input  logic signed [W-1:0]   b_j,
	input  logic signed [W-1:0]   a_k,
	input  logic signed [W-1:0]   b_k,
	input  logic signed [W-1:0]   s,
	output logic signed [2*W-1:0] prod_s2,
	output logic signed [2*W+1:0] val_s3
);
	import v3a_pkg::*;

	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;

	logic signed [W-1:0]  mx, my;
	logic signed [PW-1:0] cprod_s2;
	logic signed [W-1:0]  a_s2, b_s2;
	opcode_t              op_s2;
	logic signed [SW-1:0] val_d;

	// main multiplier operands
	always_comb begin
		mx = a_i;
		my = b_i;
		case (op)
			OP_CROSS: begin
				mx = a_j;
				my = b_k;
			end
			OP_SCALE: my = s;
			OP_MAG, OP_NORM: my = a_i;
			default: ;
		endcase
	end

	// product stage
	always_ff @(posedge clk) begin
		prod_s2  <= PW'(mx) * PW'(my);
		cprod_s2 <= PW'(a_k) * PW'(b_j);
		op_s2    <= op;
		a_s2     <= a_i;
		b_s2     <= b_i;
	end

	// lane result before clamping
	always_comb begin
		case (op_s2)
			OP_ADD:   val_d = SW'(a_s2) + SW'(b_s2);
			OP_SUB:   val_d = SW'(a_s2) - SW'(b_s2);
			OP_CROSS: val_d = (SW'(prod_s2) - SW'(cprod_s2)) >>> F;
			OP_SCALE: val_d = SW'(prod_s2) >>> F;
			default:  val_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		val_s3 <= val_d;
	end

endmodule

[sv/v3a_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module v3a_sqrt #(
	parameter int W = v3a_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic [2*W-1:0] radicand,
	output logic [W-1:0]   root
);
	localparam int RW = W + 3;

	logic [2*W-1:0] rad_s  [W];
	logic [RW-1:0]  rem_s  [W];
	logic [W-1:0]   root_s [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [2*W-1:0] rad_i;
		logic [RW-1:0]  rem_i;
		logic [W-1:0]   root_i;
		logic [RW-1:0]  acc, trial;

		if (k == 0) begin : g_first
			assign rad_i  = radicand;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign rad_i  = rad_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		// bring down next two radicand bits, try root*4+1
		assign acc   = {rem_i[RW-3:0], rad_i[2*W-1 -: 2]};
		assign trial = RW'({root_i, 2'b01});

		always_ff @(posedge clk) begin
			rad_s[k] <= rad_i << 2;
			if (acc >= trial) begin
				rem_s[k]  <= acc - trial;
				root_s[k] <= {root_i[W-2:0], 1'b1};
			end else begin
				rem_s[k]  <= acc;
				root_s[k] <= {root_i[W-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[W-1];

endmodule

[sv/v3a_div.sv]
// Pipelined restoring unsigned divider, one quotient bit per stage.
module v3a_div #(
	parameter int W = v3a_pkg::WORD_BITS_DEF,
	parameter int F = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic [W+F-1:0]  num,
	input  logic [W-1:0]    den,
	output logic [W+F-1:0]  quo
);
	localparam int NW = W + F;

	// numerator bits shift out the top while quotient bits shift in below
	logic [NW-1:0] nq_s  [NW];
	logic [W-1:0]  rem_s [NW];
	logic [W-1:0]  den_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [NW-1:0] nq_i;
		logic [W-1:0]  rem_i, den_i;
		logic [W:0]    acc, diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign nq_i  = num;
			assign rem_i = '0;
			assign den_i = den;
		end else begin : g_next
			assign nq_i  = nq_s[k-1];
			assign rem_i = rem_s[k-1];
			assign den_i = den_s[k-1];
		end

		assign acc  = {rem_i, nq_i[NW-1]};
		assign diff = acc - {1'b0, den_i};
		assign ge   = acc >= {1'b0, den_i};

		always_ff @(posedge clk) begin
			nq_s[k]  <= {nq_i[NW-2:0], ge};
			rem_s[k] <= ge ? diff[W-1:0] : acc[W-1:0];
			den_s[k] <= den_i;
		end
	end

	assign quo = nq_s[W+F-1];

endmodule

[sv/vector3_alu_unit.sv]
// Three-component fixed-point vector ALU, top level.
//
// Usage: drive opcode, a_*, b_*, scalar_in and pulse start. busy stays low,
// so a transfer happens on every clock edge where start is high; a new item
// may be issued every cycle.
// Each item yields exactly one result, shown for one cycle with done high:
// result_x/y/z, result_scalar, zero_divide and saturated. The receiver has
// no way to hold results off and must take them in that cycle.
// The delay from the accepting edge to done is the same for every opcode.
// Throughput is one item per cycle. The delay is set by the square root
// (one root bit per stage, WORD_BITS stages) followed by the divider (one
// quotient bit per stage, WORD_BITS+FRAC_BITS stages), plus input,
// product, combine and output registers.
// Three lanes work on x, y and z in parallel; the sum of lane products is
// merged for dot and magnitude, and the magnitude feeds the lane dividers
// for normalize.
// Reset clears all valid bits, so no result appears for items in flight.
module vector3_alu_unit #(
	parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [v3a_pkg::OP_BITS-1:0]         opcode,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  a_x,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  a_y,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  a_z,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  b_x,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  b_y,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  b_z,
	input  logic signed [v3a_pkg::IO_BITS-1:0]  scalar_in,
	output logic                                done,
	output logic signed [v3a_pkg::IO_BITS-1:0]  result_x,
	output logic signed [v3a_pkg::IO_BITS-1:0]  result_y,
	output logic signed [v3a_pkg::IO_BITS-1:0]  result_z,
	output logic signed [v3a_pkg::IO_BITS-1:0]  result_scalar,
	output logic                                zero_divide,
	output logic                                saturated
);
	import v3a_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int SW = 2 * W + 2;
	localparam int NW = W + F;
	localparam int CW = SW + F;

	// returns {clamped flag, clamped word}
	function automatic logic [W:0] clamp(input logic signed [CW-1:0] v);
		logic [CW-W:0] hi;
		hi = v[CW-1:W-1];
		if (hi == '0 || hi == '1)
			clamp = {1'b0, v[W-1:0]};
		else if (v[CW-1])
			clamp = {1'b1, 1'b1, {(W-1){1'b0}}};
		else
			clamp = {1'b1, 1'b0, {(W-1){1'b1}}};
	endfunction

	assign busy = 1'b0;

	// input stage
	logic                valid_s1, valid_s2, valid_s3;
	opcode_t             op_s1, op_s2, op_s3;
	logic signed [W-1:0] a_s1 [3];
	logic signed [W-1:0] b_s1 [3];
	logic signed [W-1:0] s_s1, s_s2, s_s3;
	logic signed [W-1:0] a_s2 [3];
	logic signed [W-1:0] a_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode_t'(opcode);
		a_s1[0] <= W'(a_x);
		a_s1[1] <= W'(a_y);
		a_s1[2] <= W'(a_z);
		b_s1[0] <= W'(b_x);
		b_s1[1] <= W'(b_y);
		b_s1[2] <= W'(b_z);
		s_s1    <= W'(scalar_in);
		op_s2   <= op_s1;
		op_s3   <= op_s2;
		s_s2    <= s_s1;
		s_s3    <= s_s2;
		a_s2    <= a_s1;
		a_s3    <= a_s2;
	end

	// component lanes
	logic signed [PW-1:0] prod_s2 [3];
	logic signed [SW-1:0] val_s3  [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		v3a_lane #(.W(W), .F(F)) u_lane (
			.clk     (clk),
			.op      (op_s1),
			.a_i     (a_s1[i]),
			.b_i     (b_s1[i]),
			.a_j     (a_s1[(i+1)%3]),
			.b_j     (b_s1[(i+1)%3]),
			.a_k     (a_s1[(i+2)%3]),
			.b_k     (b_s1[(i+2)%3]),
			.s       (s_s1),
			.prod_s2 (prod_s2[i]),
			.val_s3  (val_s3[i])
		);
	end

	// merge: sum of lane products for dot and magnitude
	logic signed [SW-1:0] sum_s3;

	always_ff @(posedge clk) begin
		sum_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]) + SW'(prod_s2[2]);
	end

	// square root, with side data delayed alongside
	logic [W-1:0]         mag;
	logic                 va_d   [W];
	opcode_t              opa_d  [W];
	logic signed [SW-1:0] vala_d [W][3];
	logic signed [SW-1:0] dot_d  [W];
	logic signed [W-1:0]  aa_d   [W][3];
	logic signed [W-1:0]  sa_d   [W];

	v3a_sqrt #(.W(W)) u_sqrt (
		.clk      (clk),
		.radicand (sum_s3[PW-1:0]),
		.root     (mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < W; k++) va_d[k] <= 1'b0;
		end else begin
			va_d[0] <= valid_s3;
			for (int k = 1; k < W; k++) va_d[k] <= va_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		opa_d[0]  <= op_s3;
		vala_d[0] <= val_s3;
		dot_d[0]  <= sum_s3 >>> F;
		aa_d[0]   <= a_s3;
		sa_d[0]   <= s_s3;
		for (int k = 1; k < W; k++) begin
			opa_d[k]  <= opa_d[k-1];
			vala_d[k] <= vala_d[k-1];
			dot_d[k]  <= dot_d[k-1];
			aa_d[k]   <= aa_d[k-1];
			sa_d[k]   <= sa_d[k-1];
		end
	end

	// divider setup: divisor, signs, zero check, scalar result
	opcode_t              opq;
	logic signed [W-1:0]  sq;
	logic                 is_div;
	logic [W-1:0]         s_abs, den;
	logic                 zdq;
	logic [NW-1:0]        num [3];
	logic                 negq [3];
	logic signed [SW-1:0] scalq;

	always_comb begin
		opq    = opa_d[W-1];
		sq     = sa_d[W-1];
		is_div = opq == OP_DIV;
		s_abs  = sq[W-1] ? (~sq + 1'b1) : sq;
		den    = is_div ? s_abs : mag;
		zdq    = (is_div && sq == '0) || (opq == OP_NORM && mag == '0);
		for (int i = 0; i < 3; i++) begin
			num[i]  = NW'(aa_d[W-1][i][W-1] ? (~aa_d[W-1][i] + 1'b1) : aa_d[W-1][i]) << F;
			negq[i] = aa_d[W-1][i][W-1] ^ (is_div & sq[W-1]);
		end
		case (opq)
			OP_DOT:  scalq = dot_d[W-1];
			OP_MAG:  scalq = SW'(mag);
			default: scalq = '0;
		endcase
	end

	logic [NW-1:0] quo [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3a_div #(.W(W), .F(F)) u_div (
			.clk (clk),
			.num (num[i]),
			.den (den),
			.quo (quo[i])
		);
	end

	// side data delayed alongside the dividers
	logic                 vb_d   [NW];
	opcode_t              opb_d  [NW];
	logic                 zdb_d  [NW];
	logic                 negb_d [NW][3];
	logic signed [SW-1:0] valb_d [NW][3];
	logic signed [SW-1:0] scb_d  [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NW; k++) vb_d[k] <= 1'b0;
		end else begin
			vb_d[0] <= va_d[W-1];
			for (int k = 1; k < NW; k++) vb_d[k] <= vb_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		opb_d[0]  <= opq;
		zdb_d[0]  <= zdq;
		negb_d[0] <= negq;
		valb_d[0] <= vala_d[W-1];
		scb_d[0]  <= scalq;
		for (int k = 1; k < NW; k++) begin
			opb_d[k]  <= opb_d[k-1];
			zdb_d[k]  <= zdb_d[k-1];
			negb_d[k] <= negb_d[k-1];
			valb_d[k] <= valb_d[k-1];
			scb_d[k]  <= scb_d[k-1];
		end
	end

	// final select and clamp
	opcode_t              opo;
	logic                 zdo;
	logic signed [CW-1:0] qe, wv;
	logic [W:0]           cl [3];
	logic [W:0]           cls;

	always_comb begin
		opo = opb_d[NW-1];
		zdo = zdb_d[NW-1] && (opo == OP_DIV || opo == OP_NORM);
		for (int i = 0; i < 3; i++) begin
			qe = signed'(CW'(quo[i]));
			case (opo)
				OP_ADD, OP_SUB, OP_CROSS, OP_SCALE: wv = CW'(valb_d[NW-1][i]);
				OP_DIV, OP_NORM: wv = zdo ? '0 : (negb_d[NW-1][i] ? -qe : qe);
				default: wv = '0;
			endcase
			cl[i] = clamp(wv);
		end
		cls = clamp(CW'(scb_d[NW-1]));
	end

	// output registers
	logic                done_q;
	logic signed [W-1:0] res_q [3];
	logic signed [W-1:0] scal_q;
	logic                zd_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vb_d[NW-1];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) res_q[i] <= cl[i][W-1:0];
		scal_q <= cls[W-1:0];
		zd_q   <= zdo;
		sat_q  <= cl[0][W] | cl[1][W] | cl[2][W] | cls[W];
	end

	assign done          = done_q;
	assign result_x      = IO_BITS'(res_q[0]);
	assign result_y      = IO_BITS'(res_q[1]);
	assign result_z      = IO_BITS'(res_q[2]);
	assign result_scalar = IO_BITS'(scal_q);
	assign zero_divide   = zd_q;
	assign saturated     = sat_q;

endmodule

[sv/v3a_checker.sv]
// Port-level assertions for the vector ALU and their bind to the top level.
module v3a_checker #(
	parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic signed [v3a_pkg::IO_BITS-1:0] result_x,
	input logic signed [v3a_pkg::IO_BITS-1:0] result_y,
	input logic signed [v3a_pkg::IO_BITS-1:0] result_z,
	input logic signed [v3a_pkg::IO_BITS-1:0] result_scalar,
	input logic                               zero_divide,
	input logic                               saturated
);
	import v3a_pkg::*;

	// edges from the accepting edge to the edge that takes the result
	localparam int LAT = 2 * WORD_BITS + FRAC_BITS + 4;

	// every transfer in gives a result after the fixed latency
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after transfer in");

	// no result without a matching transfer in
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without transfer in");

	// divide by zero gives all zeros and no clamping
	a_zdiv: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_divide) |-> (result_x == '0 && result_y == '0 &&
			result_z == '0 && result_scalar == '0 && !saturated))
		else $error("zero divide result not cleared");

endmodule

bind vector3_alu_unit v3a_checker #(
	.WORD_BITS (WORD_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_v3a_checker (.*);

[sim/vector3_alu_unit_tb.sv]
// Self-checking testbench for the three-component fixed-point vector ALU.
module vector3_alu_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import v3a_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int LATENCY = 2*WORD_BITS_DEF + FRAC_BITS_DEF + 3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 1330;

	typedef struct {
		opcode_t op;
		logic signed [31:0] ax, ay, az, bx, by, bz, s;
	} vec_cmd_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, rs;
		logic zdiv, sat;
	} vec_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [OP_BITS-1:0] opcode = '0;
	logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [31:0] b_x = '0, b_y = '0, b_z = '0, scalar_in = '0;
	logic done, zero_divide, saturated;
	logic signed [31:0] result_x, result_y, result_z, result_scalar;

	vec_cmd_t cmd_queue[$];
	vec_res_t expected_results[$];
	int mismatches = 0;
	int transfers_in = 0;
	int results_seen = 0;
	int op_count[8];
	int send_idle_pct = 0;
	bit hold_sender = 1'b0;
	int idle_cycles = 0;

	vector3_alu_unit DUT (.*);

	always #10 clk = ~clk;

	// Clamp a wide value to 32 bits, flagging saturation
	function automatic logic signed [31:0] clamp32(logic signed [191:0] v, ref logic sat);
		if (v > 192'sh7FFF_FFFF) begin
			sat = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -192'sh8000_0000) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Floor square root of a nonnegative wide value
	function automatic logic [191:0] isqrt_floor(logic [191:0] v);
		logic [191:0] root, bitv, t;
		root = '0;
		bitv = 192'd1 << 190;
		for (int i = 0; i < 96; i++) begin
			t = root + bitv;
			if (v >= t) begin
				v = v - t;
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Truncating signed division of a component shifted into fraction
	function automatic logic signed [191:0] fix_div(logic signed [31:0] n,
			logic signed [191:0] d);
		logic signed [191:0] num;
		num = 192'(n) <<< FRAC;
		return num / d;
	endfunction

	// Expected ALU result for one command
	function automatic vec_res_t alu_predict(vec_cmd_t c);
		logic signed [191:0] r[3], sc, mag, sq;
		logic signed [191:0] a[3], b[3], s;
		vec_res_t e;
		logic sat;
		a[0] = c.ax; a[1] = c.ay; a[2] = c.az;
		b[0] = c.bx; b[1] = c.by; b[2] = c.bz;
		s = c.s;
		r[0] = 0; r[1] = 0; r[2] = 0; sc = 0;
		sat = 1'b0;
		e.zdiv = 1'b0;
		sq = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
		case (c.op)
			OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
			OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
			OP_DOT: sc = (a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC;
			OP_CROSS: begin
				r[0] = (a[1]*b[2] - a[2]*b[1]) >>> FRAC;
				r[1] = (a[2]*b[0] - a[0]*b[2]) >>> FRAC;
				r[2] = (a[0]*b[1] - a[1]*b[0]) >>> FRAC;
			end
			OP_SCALE: for (int i = 0; i < 3; i++) r[i] = (a[i]*s) >>> FRAC;
			OP_DIV: begin
				if (s == 0) e.zdiv = 1'b1;
				else for (int i = 0; i < 3; i++) r[i] = fix_div(a[i][31:0], s);
			end
			OP_MAG: sc = isqrt_floor(sq);
			default: begin
				mag = isqrt_floor(sq);
				if (mag == 0) e.zdiv = 1'b1;
				else for (int i = 0; i < 3; i++) r[i] = fix_div(a[i][31:0], mag);
			end
		endcase
		e.rx = clamp32(r[0], sat);
		e.ry = clamp32(r[1], sat);
		e.rz = clamp32(r[2], sat);
		e.rs = clamp32(sc, sat);
		e.sat = sat;
		return e;
	endfunction

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
			4: return $signed($urandom_range(0, 32'h7FFFFF)) - 32'sh400000;
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_cmd_t make_cmd(opcode_t op, logic signed [31:0] ax,
			logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] bx,
			logic signed [31:0] by, logic signed [31:0] bz, logic signed [31:0] s);
		vec_cmd_t c;
		c.op = op; c.ax = ax; c.ay = ay; c.az = az;
		c.bx = bx; c.by = by; c.bz = bz; c.s = s;
		return c;
	endfunction

	// Driver: present next command at the falling edge
	always @(negedge clk) begin
		if (arst_n && cmd_queue.size() > 0 && !hold_sender &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			vec_cmd_t c;
			c = cmd_queue[0];
			opcode <= c.op;
			a_x <= c.ax; a_y <= c.ay; a_z <= c.az;
			b_x <= c.bx; b_y <= c.by; b_z <= c.bz;
			scalar_in <= c.s;
			start <= 1'b1;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: accept transfers and check results at the rising edge
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				vec_cmd_t c;
				c = cmd_queue.pop_front();
				expected_results.push_back(alu_predict(c));
				op_count[c.op]++;
				transfers_in++;
				moved = 1'b1;
			end
			if (done) begin
				moved = 1'b1;
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
				end else begin
					vec_res_t e;
					e = expected_results.pop_front();
					if (e.rx !== result_x || e.ry !== result_y || e.rz !== result_z ||
							e.rs !== result_scalar || e.zdiv !== zero_divide ||
							e.sat !== saturated) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: exp %h %h %h %h zd%b s%b got %h %h %h %h zd%b s%b",
								e.rx, e.ry, e.rz, e.rs, e.zdiv, e.sat, result_x, result_y,
								result_z, result_scalar, zero_divide, saturated);
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired");
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		vec_cmd_t c;
		int phase;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, every opcode, zero divisor, zero vector
		cmd_queue.push_back(make_cmd(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
			1, -1, -5, 0));
		cmd_queue.push_back(make_cmd(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
			1, -1, 0, 0));
		cmd_queue.push_back(make_cmd(OP_DOT, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
			32'sh0004_0000, -32'sh0005_0000, 32'sh0006_0000, 0));
		cmd_queue.push_back(make_cmd(OP_DOT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
		cmd_queue.push_back(make_cmd(OP_DOT, -1, 0, 0, 1, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_CROSS, 32'sh0001_0000, 0, 0, 0, 32'sh0001_0000, 0, 0));
		cmd_queue.push_back(make_cmd(OP_CROSS, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 0));
		cmd_queue.push_back(make_cmd(OP_SCALE, 32'sh0003_0000, -32'sh0001_8000, 7,
			0, 0, 0, 32'sh0000_8000));
		cmd_queue.push_back(make_cmd(OP_SCALE, 32'sh8000_0000, 32'sh7FFF_FFFF, -1,
			0, 0, 0, 32'sh8000_0000));
		cmd_queue.push_back(make_cmd(OP_DIV, 32'sh0001_0000, -32'sh0003_0000, 5,
			0, 0, 0, 32'sh0003_0000));
		cmd_queue.push_back(make_cmd(OP_DIV, 32'sh0001_0000, 2, 3, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_DIV, 32'sh7FFF_FFFF, 32'sh8000_0000, -7,
			0, 0, 0, 1));
		cmd_queue.push_back(make_cmd(OP_DIV, 32'sh8000_0000, 32'sh7FFF_FFFF, 1,
			0, 0, 0, 32'sh8000_0000));
		cmd_queue.push_back(make_cmd(OP_MAG, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_MAG, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_MAG, 0, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 0, 0, 0, 5, 5, 5, 5));
		cmd_queue.push_back(make_cmd(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(make_cmd(OP_NORM, 32'sh8000_0000, 1, -1, 0, 0, 0, 0));
		wait (cmd_queue.size() == 0);

		// Hold off until the pipeline drains
		hold_sender = 1'b1;
		wait (expected_results.size() == 0);
		hold_sender = 1'b0;

		// Random phases with varying sender idle rates
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 79 : (phase == 3) ? 20 : 0;
			for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
				c = make_cmd(opcode_t'($urandom_range(0, 7)), rand_word(), rand_word(),
					rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
				if ($urandom_range(0, 9) == 0) c.s = 0;
				if ($urandom_range(0, 19) == 0) begin
					c.ax = 0; c.ay = 0; c.az = 0;
				end
				cmd_queue.push_back(c);
			end
			wait (cmd_queue.size() == 0);
		end

		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Covered %0d transfers, %0d results; per opcode add %0d sub %0d dot %0d",
			transfers_in, results_seen, op_count[0], op_count[1], op_count[2]);
		$display("cross %0d scale %0d div %0d mag %0d norm %0d; mismatches %0d",
			op_count[3], op_count[4], op_count[5], op_count[6], op_count[7], mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
sv/v3a_pkg.sv
sv/v3a_lane.sv
sv/v3a_sqrt.sv
sv/v3a_div.sv
sv/vector3_alu_unit.sv
sv/v3a_checker.sv
sim/vector3_alu_unit_tb.sv
